FILE: hdl/lebdf_pkg.sv
// Package for the LEB128 length-prefixed deframer.
// Holds result kinds, error codes, register indexes and reset defaults.
// No dependencies.
`default_nettype none

package lebdf_pkg;

    // Result kinds.
    typedef enum logic [1:0]
    {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    // Error codes.
    typedef enum logic [1:0]
    {
        ERR_NONE      = 2'd0,
        ERR_HDR_LONG  = 2'd1,
        ERR_FRAME_LIM = 2'd2,
        ERR_CAPACITY  = 2'd3
    } err_t;

    // Configuration register indexes and port widths.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 24;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_FRAME_LEN   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BUFFER_CAPACITY = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [31:0] MAX_FRAME_LEN_RST   = 32'd65535;
    localparam logic [31:0] BUFFER_CAPACITY_RST = 32'd4096;

    // Parameter defaults.
    localparam int MAX_HEADER_BYTES_DEF = 10;
    localparam int LEN_BITS_DEF         = 24;

    // Header shape.
    localparam int HDR_CNT_BITS = 4;
    localparam int ACC_BITS     = 64;

endpackage

`default_nettype wire

FILE: hdl/leb128_length_prefixed_deframer.sv
// Results are registered in the output slot, or in the skid slot while the output slot waits.
// Throughput: one byte per cycle; in_ready drops only while the two-entry output
// buffer is full, so the output handshake alone can slow the stream.
// Reset (rst_n, asynchronous, active low): expect a header, empty accumulator,
// output empty, max_frame_len 65535 and buffer_capacity 4096.
// Depends on lebdf_pkg.
`default_nettype none

module leb128_length_prefixed_deframer #(
    parameter int MAX_HEADER_BYTES = lebdf_pkg::MAX_HEADER_BYTES_DEF,
    parameter int LEN_BITS         = lebdf_pkg::LEN_BITS_DEF,
    localparam int FL_BITS = (LEN_BITS < lebdf_pkg::CFG_DATA_BITS) ?
                             LEN_BITS : lebdf_pkg::CFG_DATA_BITS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Configuration write port.
    input  wire logic                                 cfg_we,
    input  wire logic [lebdf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [lebdf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    // Input stream.
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [7:0]                           stream_byte,
    // Result stream.
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [1:0]                                kind,
    output logic [7:0]                                payload_byte,
    output logic                                      last,
    output logic [FL_BITS-1:0]                        frame_len,
    output logic [1:0]                                error_code
);

    localparam int ACC_BITS = lebdf_pkg::ACC_BITS;
    localparam int CNT_BITS = lebdf_pkg::HDR_CNT_BITS;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         payload_byte;
        logic               last;
        logic [FL_BITS-1:0] frame_len;
        logic [1:0]         error_code;
    } result_t;

    // Configuration registers.
    logic [FL_BITS-1:0] max_len_reg;
    logic [FL_BITS-1:0] capacity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg  <= FL_BITS'(lebdf_pkg::MAX_FRAME_LEN_RST);
            capacity_reg <= FL_BITS'(lebdf_pkg::BUFFER_CAPACITY_RST);
        end
        else if (cfg_we)
        begin
            if (cfg_index == lebdf_pkg::REG_MAX_FRAME_LEN)
                max_len_reg <= cfg_data[FL_BITS-1:0];
            else if (cfg_index == lebdf_pkg::REG_BUFFER_CAPACITY)
                capacity_reg <= cfg_data[FL_BITS-1:0];
        end
    end

    // Deframer state. The accumulator keeps only the low bits of the length,
    // plus flags for any set bit above the output width and above LEN_BITS.
    logic                in_payload_reg, in_payload_next;
    logic [FL_BITS-1:0]  acc_low_reg, acc_low_next;
    logic                acc_ovf_fl_reg, acc_ovf_fl_next;
    logic                acc_ovf_len_reg, acc_ovf_len_next;
    logic [CNT_BITS-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [FL_BITS-1:0]  remain_reg, remain_next;
    logic [FL_BITS-1:0]  cur_len_reg, cur_len_next;

    // Output buffer: main slot and skid slot.
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;

    // Per-byte decode.
    logic                accept;
    logic                pop;
    logic [6:0]          shamt;
    logic [ACC_BITS-1:0] contrib;
    logic [FL_BITS-1:0]  len_low;
    logic                len_ovf_fl;
    logic                len_ovf_len;
    logic [CNT_BITS-1:0] cnt_inc;
    logic [FL_BITS-1:0]  remain_dec;
    logic                res_valid;
    result_t             res;

    assign accept   = in_valid && in_ready;
    assign pop      = out_valid_reg && out_ready;
    assign in_ready = !skid_valid_reg;

    // Header byte at index k lands at bit 7k; bits past bit 63 fall off.
    assign shamt   = {hdr_cnt_reg, 3'b000} - {3'b000, hdr_cnt_reg};
    assign contrib = ACC_BITS'(stream_byte[6:0]) << shamt;

    assign len_low     = acc_low_reg | contrib[FL_BITS-1:0];
    assign len_ovf_fl  = acc_ovf_fl_reg  || ((contrib >> FL_BITS) != '0);
    assign len_ovf_len = acc_ovf_len_reg || ((contrib >> LEN_BITS) != '0);
    assign cnt_inc     = hdr_cnt_reg + CNT_BITS'(1);
    assign remain_dec  = remain_reg - FL_BITS'(1);

    // Next state and result for one accepted byte.
    always_comb
    begin
        in_payload_next  = in_payload_reg;
        acc_low_next     = acc_low_reg;
        acc_ovf_fl_next  = acc_ovf_fl_reg;
        acc_ovf_len_next = acc_ovf_len_reg;
        hdr_cnt_next     = hdr_cnt_reg;
        remain_next      = remain_reg;
        cur_len_next     = cur_len_reg;
        res_valid        = 1'b0;
        res              = '0;

        if (accept)
        begin
            if (in_payload_reg)
            begin
                // Payload byte passes straight on.
                remain_next      = remain_dec;
                in_payload_next  = (remain_dec != '0);
                res_valid        = 1'b1;
                res.kind         = lebdf_pkg::KIND_PAYLOAD;
                res.payload_byte = stream_byte;
                res.last         = (remain_dec == '0);
                res.frame_len    = cur_len_reg;
                res.error_code   = lebdf_pkg::ERR_NONE;
            end
            else if (stream_byte[7])
            begin
                // Continuation byte: accumulate, or give up on an overlong header.
                if (cnt_inc >= CNT_BITS'(MAX_HEADER_BYTES))
                begin
                    acc_low_next     = '0;
                    acc_ovf_fl_next  = 1'b0;
                    acc_ovf_len_next = 1'b0;
                    hdr_cnt_next     = '0;
                    res_valid        = 1'b1;
                    res.kind         = lebdf_pkg::KIND_ERROR;
                    res.error_code   = lebdf_pkg::ERR_HDR_LONG;
                end
                else
                begin
                    acc_low_next     = len_low;
                    acc_ovf_fl_next  = len_ovf_fl;
                    acc_ovf_len_next = len_ovf_len;
                    hdr_cnt_next     = cnt_inc;
                end
            end
            else
            begin
                // Final header byte: check the length against both limits.
                acc_low_next     = '0;
                acc_ovf_fl_next  = 1'b0;
                acc_ovf_len_next = 1'b0;
                hdr_cnt_next     = '0;
                if (len_ovf_fl || (len_low > max_len_reg))
                begin
                    res_valid      = 1'b1;
                    res.kind       = lebdf_pkg::KIND_ERROR;
                    res.frame_len  = len_ovf_len ? '1 : len_low;
                    res.error_code = lebdf_pkg::ERR_FRAME_LIM;
                end
                else if (len_low > capacity_reg)
                begin
                    res_valid      = 1'b1;
                    res.kind       = lebdf_pkg::KIND_ERROR;
                    res.frame_len  = len_low;
                    res.error_code = lebdf_pkg::ERR_CAPACITY;
                end
                else if (len_low == '0)
                begin
                    res_valid      = 1'b1;
                    res.kind       = lebdf_pkg::KIND_EMPTY;
                    res.last       = 1'b1;
                    res.error_code = lebdf_pkg::ERR_NONE;
                end
                else
                begin
                    in_payload_next = 1'b1;
                    remain_next     = len_low;
                    cur_len_next    = len_low;
                end
            end
        end
    end

    // Output buffer: new results go to the main slot when it is empty or frees this cycle,
    // else to the skid slot.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;

        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || pop)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_payload_reg  <= 1'b0;
            acc_low_reg     <= '0;
            acc_ovf_fl_reg  <= 1'b0;
            acc_ovf_len_reg <= 1'b0;
            hdr_cnt_reg     <= '0;
            remain_reg      <= '0;
            cur_len_reg     <= '0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            in_payload_reg  <= in_payload_next;
            acc_low_reg     <= acc_low_next;
            acc_ovf_fl_reg  <= acc_ovf_fl_next;
            acc_ovf_len_reg <= acc_ovf_len_next;
            hdr_cnt_reg     <= hdr_cnt_next;
            remain_reg      <= remain_next;
            cur_len_reg     <= cur_len_next;
            out_valid_reg   <= out_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_reg.kind;
    assign payload_byte = out_reg.payload_byte;
    assign last         = out_reg.last;
    assign frame_len    = out_reg.frame_len;
    assign error_code   = out_reg.error_code;

    // The skid slot only fills behind a waiting result.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot holds a result while the output slot is empty");

    // An error code appears exactly on error results.
    a_err_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_reg.kind == lebdf_pkg::KIND_ERROR) ==
                           (out_reg.error_code != lebdf_pkg::ERR_NONE)))
        else $error("error code does not match result kind");

    // The header count never reaches the header byte limit.
    a_hdr_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_cnt_reg < CNT_BITS'(MAX_HEADER_BYTES))
        else $error("header byte count reached the limit");

    // A byte taken while a payload is pending with more than one left stays in payload.
    a_payload_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_payload_reg && (remain_reg > FL_BITS'(1))) |=> in_payload_reg)
        else $error("payload ended early");

endmodule

`default_nettype wire

FILE: verif/leb128_length_prefixed_deframer_test.sv
// Self-checking testbench for the LEB128 length-prefixed deframer.
// Drives framed byte streams under several register settings and checks every result.
// Depends on lebdf_pkg and leb128_length_prefixed_deframer.
`timescale 1ns / 1ps

module leb128_length_prefixed_deframer_test;

    localparam int HDR_LIMIT       = lebdf_pkg::MAX_HEADER_BYTES_DEF;
    localparam int PHASES          = 7;
    localparam int BYTES_PER_PHASE = 275;
    localparam int REPORT_LIMIT    = 10;
    localparam int IDLE_LIMIT      = 3000;
    localparam logic [23:0] LEN_MAX = 24'hFFFFFF;

    // One result item of the deframer.
    typedef struct packed
    {
        lebdf_pkg::kind_t kind;
        logic [7:0]       data;
        logic             last;
        logic [23:0]      len;
        lebdf_pkg::err_t  code;
    } deframe_result_t;

    // Clock, reset and block ports.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [lebdf_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [lebdf_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  stream_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic        last;
    logic [23:0] frame_len;
    logic [1:0]  error_code;

    // Stream bytes waiting to be sent and results still owed by the block.
    logic [7:0]      pending_bytes[$];
    deframe_result_t due_results[$];

    // Deframer state as predicted by the testbench.
    logic        in_frame = 1'b0;
    logic [63:0] len_acc = '0;
    logic [3:0]  hdr_count = '0;
    logic [23:0] bytes_left = '0;
    logic [23:0] frame_len_cur = '0;
    logic [23:0] frame_limit = 24'(lebdf_pkg::MAX_FRAME_LEN_RST);
    logic [23:0] buf_capacity = 24'(lebdf_pkg::BUFFER_CAPACITY_RST);

    // Run bookkeeping.
    int mismatches = 0;
    int results_checked = 0;
    int bytes_sent = 0;
    int payload_seen = 0;
    int empty_seen = 0;
    int rejects_seen = 0;
    int settings_used = 0;
    int idle_cycles = 0;
    int gap_left = 0;
    int stall_left = 0;
    int tx_quiet = 0;
    int rx_quiet = 0;
    logic [23:0] phase_limit [PHASES];
    logic [23:0] phase_capacity [PHASES];

    leb128_length_prefixed_deframer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .stream_byte  (stream_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .payload_byte (payload_byte),
        .last         (last),
        .frame_len    (frame_len),
        .error_code   (error_code)
    );

    always #6 clk = ~clk;

    // Advance the predicted deframer by one stream byte and record any result it owes.
    function automatic void decode_byte(input logic [7:0] b);
        logic [63:0] len;
        int unsigned shift;
        deframe_result_t r;
        if (in_frame)
        begin
            bytes_left = bytes_left - 24'd1;
            if (bytes_left == 0)
                in_frame = 1'b0;
            r = '{kind: lebdf_pkg::KIND_PAYLOAD, data: b, last: (bytes_left == 0),
                  len: frame_len_cur, code: lebdf_pkg::ERR_NONE};
            due_results.push_back(r);
            return;
        end
        // Seven length bits per header byte; bits past bit 63 fall off.
        shift = 7 * hdr_count;
        if (shift < 64)
            len_acc = len_acc | (64'(b[6:0]) << shift);
        if (b[7])
        begin
            hdr_count = hdr_count + 4'd1;
            if (hdr_count >= HDR_LIMIT)
            begin
                len_acc = '0;
                hdr_count = '0;
                r = '{kind: lebdf_pkg::KIND_ERROR, data: 8'h00, last: 1'b0, len: 24'd0,
                      code: lebdf_pkg::ERR_HDR_LONG};
                due_results.push_back(r);
            end
            return;
        end
        len = len_acc;
        len_acc = '0;
        hdr_count = '0;
        // The frame limit is checked ahead of the buffer capacity.
        if (len > frame_limit || len > buf_capacity)
        begin
            r = '{kind: lebdf_pkg::KIND_ERROR, data: 8'h00, last: 1'b0,
                  len: (len > LEN_MAX) ? LEN_MAX : len[23:0],
                  code: (len > frame_limit) ? lebdf_pkg::ERR_FRAME_LIM :
                                              lebdf_pkg::ERR_CAPACITY};
            due_results.push_back(r);
        end
        else if (len == 0)
        begin
            r = '{kind: lebdf_pkg::KIND_EMPTY, data: 8'h00, last: 1'b1, len: 24'd0,
                  code: lebdf_pkg::ERR_NONE};
            due_results.push_back(r);
        end
        else
        begin
            in_frame = 1'b1;
            bytes_left = len[23:0];
            frame_len_cur = len[23:0];
        end
    endfunction

    // Gap length for either side: mostly none or short, a few long, and quiet stretches.
    function automatic int pick_gap(inout int quiet);
        int unsigned r;
        if (quiet > 0)
        begin
            quiet = quiet - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            quiet = $urandom_range(50, 200);
            return 0;
        end
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Frame length: mostly small, otherwise at the register limits or far beyond them.
    function automatic logic [63:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 64'($urandom_range(0, 12));
        if (r < 65)
            return 64'($urandom_range(13, 64));
        case ($urandom_range(0, 8))
            0: return 64'(frame_limit);
            1: return 64'(frame_limit) + 64'd1;
            2: return 64'(buf_capacity);
            3: return 64'(buf_capacity) + 64'd1;
            4: return 64'(LEN_MAX);
            5: return 64'h100_0000;
            6: return {$urandom, $urandom};
            7: return 64'h1 << $urandom_range(0, 63);
            default: return 64'd0;
        endcase
    endfunction

    // Queue one frame: a header padded by zero groups up to the byte limit, with
    // junk in the dropped bits of a tenth byte, then the payload if it is accepted.
    function automatic int queue_frame(input logic [63:0] len, input int pad,
                                       input logic [5:0] junk);
        int groups;
        int total;
        int count;
        int i;
        logic [63:0] rest;
        logic [7:0] b;
        groups = 1;
        rest = len >> 7;
        while (rest != 0)
        begin
            groups++;
            rest = rest >> 7;
        end
        total = (groups + pad > HDR_LIMIT) ? HDR_LIMIT : groups + pad;
        for (i = 0; i < total; i++)
        begin
            b = {(i < total - 1), 7'(len >> (7 * i))};
            if (i == HDR_LIMIT - 1)
                b[6:1] = b[6:1] | junk;
            pending_bytes.push_back(b);
        end
        count = total;
        if (len != 0 && len <= frame_limit && len <= buf_capacity)
        begin
            for (i = 0; i < int'(len); i++)
                pending_bytes.push_back(8'($urandom));
            count += int'(len);
        end
        return count;
    endfunction

    // Register write; the predicted registers follow at the same edge.
    task automatic write_reg(input logic [lebdf_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [23:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == lebdf_pkg::REG_MAX_FRAME_LEN)
            frame_limit = value;
        else
            buf_capacity = value;
    endtask

    // Hold until every queued byte is sent and every owed result has come,
    // then let the pipeline settle.
    task automatic drain();
        do
            @(posedge clk);
        while (pending_bytes.size() != 0 || in_valid || due_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Sender: presents queued bytes, with random gaps between items.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                decode_byte(stream_byte);
                bytes_sent++;
                gap_left = pick_gap(tx_quiet);
            end
            else if (!in_valid && gap_left > 0)
            begin
                gap_left--;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left == 0 && pending_bytes.size() != 0)
                begin
                    in_valid <= 1'b1;
                    stream_byte <= pending_bytes.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls at random and checks each result against the oldest one owed.
    always @(posedge clk)
    begin
        deframe_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("Unexpected result: kind %0d byte %02h last %0d len %0d code %0d",
                                 kind, payload_byte, last, frame_len, error_code);
                end
                else
                begin
                    want = due_results.pop_front();
                    results_checked++;
                    if (kind !== want.kind || payload_byte !== want.data ||
                        last !== want.last || frame_len !== want.len ||
                        error_code !== want.code)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"Result %0d wrong: expected kind %0d byte %02h last %0d ",
                                      "len %0d code %0d, got kind %0d byte %02h last %0d ",
                                      "len %0d code %0d"},
                                     results_checked, want.kind, want.data, want.last,
                                     want.len, want.code, kind, payload_byte, last,
                                     frame_len, error_code);
                    end
                    case (want.kind)
                        lebdf_pkg::KIND_PAYLOAD: payload_seen++;
                        lebdf_pkg::KIND_EMPTY:   empty_seen++;
                        default:                 rejects_seen++;
                    endcase
                end
                stall_left = pick_gap(rx_quiet);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            out_ready <= (stall_left == 0);
        end
    end

    // Watchdog: ends the run if neither side moves an item for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout after %0d cycles without progress", IDLE_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Stimulus: directed frames under reset settings, then random phases.
    initial
    begin
        int ph;
        int filled;
        int i;
        int unsigned r;
        logic [63:0] len;

        phase_limit    = '{24'd65535, 24'd0, LEN_MAX, 24'd300, 24'd20, 24'd0, LEN_MAX};
        phase_capacity = '{24'd4096,  24'd0, LEN_MAX, 24'd40,  LEN_MAX, 24'd0, 24'd0};
        phase_limit[5]    = 24'($urandom_range(0, 100));
        phase_capacity[5] = 24'($urandom_range(0, 100));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Empty frame, one-byte frame, two-byte frame with extreme payload values.
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'h01);
        pending_bytes.push_back(8'hAB);
        pending_bytes.push_back(8'h02);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        // Header that never ends within the byte limit.
        for (i = 0; i < HDR_LIMIT; i++)
            pending_bytes.push_back(8'h80);
        // Just above the buffer capacity, above both limits, and all-ones header bytes.
        pending_bytes.push_back(8'h81);
        pending_bytes.push_back(8'h20);
        pending_bytes.push_back(8'h80);
        pending_bytes.push_back(8'h80);
        pending_bytes.push_back(8'h04);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'h7F);
        drain();

        for (ph = 0; ph < PHASES; ph++)
        begin
            write_reg(lebdf_pkg::REG_MAX_FRAME_LEN, phase_limit[ph]);
            write_reg(lebdf_pkg::REG_BUFFER_CAPACITY, phase_capacity[ph]);
            settings_used++;
            filled = 0;
            while (filled < BYTES_PER_PHASE)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                begin
                    // Overlong header with random length bits.
                    for (i = 0; i < HDR_LIMIT; i++)
                        pending_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
                    filled += HDR_LIMIT;
                end
                else
                begin
                    len = pick_length();
                    if (len <= frame_limit && len <= buf_capacity && len > 200)
                        len = len % 32;
                    if (r < 16)
                        filled += queue_frame(len, HDR_LIMIT, 6'($urandom));
                    else if (r < 30)
                        filled += queue_frame(len, $urandom_range(1, 3), 6'd0);
                    else
                        filled += queue_frame(len, 0, 6'd0);
                end
            end
            // The stimulus waits here until every queued byte is sent and every owed result has come.
            drain();
        end

        repeat (10) @(posedge clk);
        mismatches += due_results.size();
        $display("Checked %0d results from %0d stream bytes: %0d payload bytes, %0d empty frames,",
                 results_checked, bytes_sent, payload_seen, empty_seen);
        $display("%0d rejected headers, under reset settings and %0d written register settings.",
                 rejects_seen, settings_used);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
